[hdl/fde_pkg.sv]
// Shared widths, register map and reset values of the feedback delay echo.
package fde_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAX_DELAY = 65536;
	localparam int ADDR_W    = $clog2(MAX_DELAY);
	localparam int LEN_W     = ADDR_W + 1;
	localparam int GAIN_W    = 15;
	localparam int FRAC_W    = 15;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int QUO_W     = ACC_W - FRAC_W;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 3;

	localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(22049);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
	localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_DELAY);

	// Register select, taken from paddr[2] (registers at byte 0 and 4).
	typedef enum logic {
		REG_DELAY_LENGTH  = 1'b0,
		REG_FEEDBACK_GAIN = 1'b1
	} reg_sel_t;

endpackage

[hdl/feedback_delay_echo.sv]
// Feedback delay (echo) line: circular delay memory with saturating feedback.
// Usage:
//   Input stream s_*: one signed 16-bit sample per beat in s_tdata.
//   Output stream m_*: one beat per input beat, in order; m_tdata holds the
//   sample read from the delay memory at the current position, m_tuser is
//   set when the feedback sum written back at that position was clipped.
//   APB port: delay_length at byte 0, feedback_gain at byte 4; write only
//   while the stream is idle.
// Timing:
//   One beat per cycle while m_tready stays high. The memory read lands in
//   the read stage at the accepting edge; the multiply, saturate and
//   write-back fill the output register that drives m_* when it advances.
//   A forwarding register covers a read that meets the write to the same
//   entry (delay length of one).
// Reset:
//   Position, fill count and registers reset; the memory is not swept.
//   Entries at or above the fill count read as zero, so beats flow at once.
// Stall:
//   When m_tready is low the output register holds, one more beat can enter
//   the read stage, then s_tready drops until the output moves again.
module feedback_delay_echo (
	input  logic                                clk,
	input  logic                                arst_n,
	// stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fde_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_in
	// stream out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fde_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] echo_out
	output logic                                m_tuser,   // [0] clipped
	// APB config
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fde_pkg::PADDR_W-1:0]         paddr,
	input  logic [fde_pkg::DATA_W-1:0]          pwdata,
	output logic [fde_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	// config registers
	logic [fde_pkg::LEN_W-1:0]  len_q;
	logic [fde_pkg::GAIN_W-1:0] gain_q;
	logic                       cfg_wr;
	fde_pkg::reg_sel_t          cfg_sel;

	// position and fill count (entries below hw_q have been written)
	logic [fde_pkg::ADDR_W-1:0] pos_q;
	logic [fde_pkg::LEN_W-1:0]  hw_q;
	logic [fde_pkg::LEN_W-1:0]  len_eff;
	logic [fde_pkg::LEN_W-1:0]  pos_inc;

	// delay memory
	logic signed [fde_pkg::SAMPLE_W-1:0] mem [fde_pkg::MAX_DELAY];
	logic signed [fde_pkg::SAMPLE_W-1:0] rd_data_s1;

	// read stage
	logic                                v_s1;
	logic [fde_pkg::ADDR_W-1:0]          addr_s1;
	logic signed [fde_pkg::SAMPLE_W-1:0] x_s1;

	// write forwarding: the write that landed at the edge of the last read
	logic                                fwd_v_q;
	logic [fde_pkg::ADDR_W-1:0]          fwd_addr_q;
	logic signed [fde_pkg::SAMPLE_W-1:0] fwd_data_q;

	// output register
	logic                                out_v_q;
	logic signed [fde_pkg::SAMPLE_W-1:0] echo_q;
	logic                                clip_q;

	logic in_acc, adv, wr_en;
	logic signed [fde_pkg::SAMPLE_W-1:0] y;
	logic signed [fde_pkg::PROD_W-1:0]   prod;
	logic signed [fde_pkg::ACC_W-1:0]    acc;
	logic signed [fde_pkg::ACC_W-1:0]    acc_adj;
	logic signed [fde_pkg::QUO_W-1:0]    quo;
	logic signed [fde_pkg::SAMPLE_W-1:0] wr_data;
	logic                                clip;

	// ---- APB ----
	assign pready  = 1'b1;
	assign cfg_sel = fde_pkg::reg_sel_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		unique case (cfg_sel)
			fde_pkg::REG_DELAY_LENGTH:  prdata = fde_pkg::DATA_W'(len_q);
			fde_pkg::REG_FEEDBACK_GAIN: prdata = fde_pkg::DATA_W'(gain_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= fde_pkg::LEN_RESET;
			gain_q <= fde_pkg::GAIN_RESET;
		end else if (cfg_wr) begin
			if (cfg_sel == fde_pkg::REG_DELAY_LENGTH) begin
				len_q <= pwdata[fde_pkg::LEN_W-1:0];
			end else begin
				gain_q <= pwdata[fde_pkg::GAIN_W-1:0];
			end
		end
	end

	// ---- handshake ----
	assign adv      = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = v_s1 && adv;

	// ---- position ----
	always_comb begin
		if (len_q == '0) begin
			len_eff = fde_pkg::LEN_W'(1);
		end else if (len_q > fde_pkg::LEN_MAX) begin
			len_eff = fde_pkg::LEN_MAX;
		end else begin
			len_eff = len_q;
		end
		pos_inc = {1'b0, pos_q} + fde_pkg::LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (pos_inc >= len_eff) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[fde_pkg::ADDR_W-1:0];
			end
		end
	end

	// writes go to position order, so the written set is always a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (wr_en && ({1'b0, addr_s1} == hw_q)) begin
			hw_q <= hw_q + fde_pkg::LEN_W'(1);
		end
	end

	// ---- delay memory, read on accept, write from the read stage ----
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (in_acc) begin
			rd_data_s1 <= mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1    <= 1'b1;
				fwd_v_q <= wr_en;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1    <= pos_q;
			x_s1       <= s_tdata;
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wr_data;
		end
	end

	// ---- feedback arithmetic ----
	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_s1)) begin
			y = fwd_data_q;
		end else if ({1'b0, addr_s1} < hw_q) begin
			y = rd_data_s1;
		end else begin
			y = '0;
		end
		prod = y * $signed({1'b0, gain_q});
		acc  = {{(fde_pkg::ACC_W-fde_pkg::SAMPLE_W-fde_pkg::FRAC_W){x_s1[fde_pkg::SAMPLE_W-1]}},
			x_s1, {fde_pkg::FRAC_W{1'b0}}} + fde_pkg::ACC_W'(prod);
		// truncate toward zero: bias negatives before the shift
		acc_adj = acc[fde_pkg::ACC_W-1]
			? acc + fde_pkg::ACC_W'((1 << fde_pkg::FRAC_W) - 1) : acc;
		quo = acc_adj[fde_pkg::ACC_W-1:fde_pkg::FRAC_W];
		clip = (quo[fde_pkg::QUO_W-1:fde_pkg::SAMPLE_W-1] != '0)
			&& (quo[fde_pkg::QUO_W-1:fde_pkg::SAMPLE_W-1] != '1);
		if (!clip) begin
			wr_data = quo[fde_pkg::SAMPLE_W-1:0];
		end else if (quo[fde_pkg::QUO_W-1]) begin
			wr_data = {1'b1, {(fde_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			wr_data = {1'b0, {(fde_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			echo_q <= y;
			clip_q <= clip;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = echo_q;
	assign m_tuser  = clip_q;

endmodule

[hdl/fde_checker.sv]
// Port-level checks for the feedback delay echo, bound to the top level.
module fde_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [fde_pkg::SAMPLE_W-1:0] m_tdata,
	input logic                         m_tuser,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [fde_pkg::PADDR_W-1:0]  paddr,
	input logic [fde_pkg::DATA_W-1:0]   pwdata,
	input logic [fde_pkg::DATA_W-1:0]   prdata
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed under stall");

	// with the output register empty the input side is never blocked
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// gain write reads back next cycle
	a_gain_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2]) ##1 (!pwrite && paddr[2])
		|-> prdata == fde_pkg::DATA_W'($past(pwdata[fde_pkg::GAIN_W-1:0])))
		else $error("feedback_gain readback mismatch");

	// length write reads back next cycle
	a_len_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && !paddr[2]) ##1 (!pwrite && !paddr[2])
		|-> prdata == fde_pkg::DATA_W'($past(pwdata[fde_pkg::LEN_W-1:0])))
		else $error("delay_length readback mismatch");

endmodule

bind feedback_delay_echo fde_checker u_fde_checker (.*);

[verif/tb_feedback_delay_echo.sv]
// Self-checking testbench for the feedback delay echo line: stream traffic, APB setup, echo check.
module tb_feedback_delay_echo;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected output beat: delayed sample and clip flag.
	typedef struct packed {
		logic [fde_pkg::SAMPLE_W-1:0] echo;
		logic                         clip;
	} echo_beat_t;

	// Tracks the delay line contents and holds the echoes still owed by the block.
	class echo_tracker;
		bit signed [fde_pkg::SAMPLE_W-1:0] line_mem [fde_pkg::MAX_DELAY];
		int unsigned                       pos;
		bit [fde_pkg::LEN_W-1:0]           len_reg  = fde_pkg::LEN_RESET;
		bit [fde_pkg::GAIN_W-1:0]          gain_reg = fde_pkg::GAIN_RESET;
		echo_beat_t                        echo_due [$];
		int                                errs;

		// Accepted input sample: read the tap, write back the saturated feedback sum.
		function void take_sample(logic [fde_pkg::SAMPLE_W-1:0] raw);
			longint signed x;
			longint signed y;
			longint signed acc;
			int unsigned   span;
			bit            clip;
			x = longint'($signed(raw));
			y = longint'(line_mem[pos]);
			acc = (x * 32768 + y * longint'(gain_reg)) / 32768;
			clip = 1'b0;
			if (acc > 32767) begin
				acc = 32767;
				clip = 1'b1;
			end else if (acc < -32768) begin
				acc = -32768;
				clip = 1'b1;
			end
			echo_due.push_back('{echo: y[fde_pkg::SAMPLE_W-1:0], clip: clip});
			line_mem[pos] = acc[fde_pkg::SAMPLE_W-1:0];
			// zero length behaves as one, oversize clamps to the memory depth
			if (len_reg == 0)
				span = 1;
			else if (len_reg > fde_pkg::LEN_MAX)
				span = fde_pkg::MAX_DELAY;
			else
				span = len_reg;
			pos++;
			if (pos >= span)
				pos = 0;
		endfunction

		function void check_echo(logic [fde_pkg::SAMPLE_W-1:0] echo, logic clip);
			echo_beat_t want;
			if (echo_due.size() == 0) begin
				$error("echo_out: no beat expected, got %0d", $signed(echo));
				errs++;
				return;
			end
			want = echo_due.pop_front();
			if (echo !== want.echo) begin
				$error("echo_out mismatch: expected %0d, got %0d",
					$signed(want.echo), $signed(echo));
				errs++;
			end
			if (clip !== want.clip) begin
				$error("clipped mismatch: expected %0b, got %0b", want.clip, clip);
				errs++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [fde_pkg::SAMPLE_W-1:0] s_tdata;    // [15:0] sample_in
	logic                         m_tvalid;
	logic                         m_tready;
	logic [fde_pkg::SAMPLE_W-1:0] m_tdata;    // [15:0] echo_out
	logic                         m_tuser;    // [0] clipped
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [fde_pkg::PADDR_W-1:0]  paddr;
	logic [fde_pkg::DATA_W-1:0]   pwdata;
	logic [fde_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	echo_tracker sb = new();

	// Idle rates in percent, changed per phase.
	int tx_idle_pct;
	int rx_idle_pct;
	// Long receiver hold-off: requested by stimulus, counted down by the sink.
	bit hold_req;
	int hold_left;

	feedback_delay_echo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Sink side: random backpressure, or a long hold so the pipe fills and s_tready drops.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 300;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else
			m_tready = ($urandom_range(99) >= rx_idle_pct);
	end

	// Output beats are checked on the edge that moves them.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_echo(m_tdata, m_tuser);
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	// One input beat. s_tvalid stays high afterwards so back-to-back beats need no gap.
	task automatic send_sample(logic [fde_pkg::SAMPLE_W-1:0] x);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = x;
		do @(posedge clk); while (!s_tready);
		sb.take_sample(x);
	endtask

	// Stop sending and wait until every owed echo has come out, plus pipeline slack.
	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.echo_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Two-phase APB transfer; pready is sampled on the access edge.
	task automatic apb_xfer(bit wr, fde_pkg::reg_sel_t sel,
		logic [fde_pkg::DATA_W-1:0] wdata, output logic [fde_pkg::DATA_W-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {sel, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Register write while idle, model update, then readback.
	task automatic set_reg(fde_pkg::reg_sel_t sel, logic [fde_pkg::DATA_W-1:0] val);
		logic [fde_pkg::DATA_W-1:0] rd;
		drain();
		apb_xfer(1'b1, sel, val, rd);
		if (sel == fde_pkg::REG_DELAY_LENGTH)
			sb.len_reg = val[fde_pkg::LEN_W-1:0];
		else
			sb.gain_reg = val[fde_pkg::GAIN_W-1:0];
		apb_xfer(1'b0, sel, '0, rd);
		if (rd !== val) begin
			$error("%s readback mismatch: expected %0d, got %0d",
				sel == fde_pkg::REG_DELAY_LENGTH ? "delay_length" : "feedback_gain",
				val, rd);
			sb.errs++;
		end
	endtask

	function automatic logic [fde_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2, 3:    return fde_pkg::SAMPLE_W'($urandom_range(511) - 256);
			default: return fde_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly short delays so echoes and feedback show up within the run.
	function automatic logic [fde_pkg::DATA_W-1:0] pick_length();
		case ($urandom_range(19))
			0:       return 0;
			1:       return 1;
			2:       return fde_pkg::MAX_DELAY;
			3:       return 131071;
			4:       return $urandom_range(131071, fde_pkg::MAX_DELAY + 1);
			5:       return $urandom_range(fde_pkg::MAX_DELAY - 1, 2);
			default: return $urandom_range(48, 1);
		endcase
	endfunction

	function automatic logic [fde_pkg::DATA_W-1:0] pick_gain();
		case ($urandom_range(7))
			0:       return 0;
			1, 2:    return 32767;
			3:       return $urandom_range(20000, 12000);
			default: return $urandom_range(32767);
		endcase
	endfunction

	// Random segments, most under a fresh setting; the length often drops below the position.
	task automatic run_random(int n_items, bit long_hold, bit mid_pause);
		int sent;
		int seg;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) != 0)
				set_reg(fde_pkg::REG_DELAY_LENGTH, pick_length());
			if ($urandom_range(2) != 0)
				set_reg(fde_pkg::REG_FEEDBACK_GAIN, pick_gain());
			seg = $urandom_range(60, 10);
			if (long_hold && sent == 0)
				hold_req = 1'b1;
			for (int k = 0; k < seg; k++) begin
				if (mid_pause && sent == n_items / 2)
					drain();
				send_sample(pick_sample());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		hold_left = 0;
		tx_idle_pct = 16;
		rx_idle_pct = 86;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting, memory reads back as cleared
		send_sample(16'sh1234);
		send_sample(16'sh8000);

		// Length one at full gain: same entry read and written every beat,
		// driving into positive then negative saturation
		set_reg(fde_pkg::REG_DELAY_LENGTH, 1);
		set_reg(fde_pkg::REG_FEEDBACK_GAIN, 32767);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh0000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh0001);
		send_sample(16'shffff);

		// Zero length acts as one
		set_reg(fde_pkg::REG_DELAY_LENGTH, 0);
		send_sample(16'sh4000);
		send_sample(16'sh4000);
		send_sample(16'shc000);

		// No feedback: echo is the plain delayed input
		set_reg(fde_pkg::REG_DELAY_LENGTH, 3);
		set_reg(fde_pkg::REG_FEEDBACK_GAIN, 0);
		send_sample(16'sh0101);
		send_sample(16'shfefe);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);

		// Length lowered below the current position: that slot is still used,
		// then the position wraps to zero
		set_reg(fde_pkg::REG_DELAY_LENGTH, 8);
		set_reg(fde_pkg::REG_FEEDBACK_GAIN, 32767);
		for (int k = 0; k < 5; k++)
			send_sample(16'sh6000);
		set_reg(fde_pkg::REG_DELAY_LENGTH, 2);
		send_sample(16'sh6000);
		send_sample(16'sh6000);
		send_sample(16'sh6000);

		// Oversize length clamps to the memory depth
		set_reg(fde_pkg::REG_DELAY_LENGTH, 131071);
		send_sample(16'sh2222);
		send_sample(16'shdddd);

		// Random traffic under three idle profiles; a mid-run drain in the first,
		// a long sink hold-off in the last while the source keeps pushing
		run_random(560, 1'b0, 1'b1);
		tx_idle_pct = 86;
		rx_idle_pct = 16;
		run_random(560, 1'b0, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(560, 1'b1, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errs == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
